### design/rk4_harmonic_oscillator_step_macros.svh
// assertion macros for the rk4 harmonic oscillator step block
// used by the top level only; no other dependencies
`ifndef RK4_HARMONIC_OSCILLATOR_STEP_MACROS_SVH
`define RK4_HARMONIC_OSCILLATOR_STEP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RK4HO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RK4HO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rk4ho_pkg.sv
// shared constants, register codes and widths for the rk4 oscillator step block
// no dependencies
`default_nettype none

package rk4ho_pkg;

   localparam int FRAC_BITS_DEF  = 28;
   localparam int TIME_WIDTH_DEF = 48;

   localparam int DT_W       = 28;
   localparam int POS_W      = 32;
   localparam int A_W        = POS_W + 1;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = (DT_W + DIGIT_W - 1) / DIGIT_W;
   localparam int DT_PAD_W   = NUM_DIGITS * DIGIT_W;
   localparam int PROD_W     = A_W + DT_PAD_W;
   localparam int TIME_OUT_W = 48;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 2 * POS_W + TIME_OUT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DT_W-1:0]         STEP_SIZE_RST = DT_W'(2684355);
   localparam logic signed [POS_W-1:0] INIT_POS_RST  = POS_W'(268435456);
   localparam logic signed [POS_W-1:0] INIT_VEL_RST  = '0;

   localparam logic signed [POS_W-1:0] Q_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] Q_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE = 2'd0,
      CSR_INIT_POS  = 2'd1,
      CSR_INIT_VEL  = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

### design/rk4ho_mul.sv
// digit-serial multiplier lane: signed operand times unsigned step size,
// one 4-bit digit of the step size per cycle, result shifted by FRAC_BITS
// depends on rk4ho_pkg
`default_nettype none

module rk4ho_mul #(
   parameter int FRAC_BITS = rk4ho_pkg::FRAC_BITS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  logic signed [rk4ho_pkg::A_W-1:0]                  operand,
   input  logic [rk4ho_pkg::DT_W-1:0]                        step_size,
   output logic                                              done,
   output logic signed [rk4ho_pkg::PROD_W-FRAC_BITS-1:0]     product
);
   import rk4ho_pkg::*;

   localparam int CNT_W = $clog2(NUM_DIGITS + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DT_PAD_W-1:0]        dt_ff, dt_in;
   logic signed [A_W-1:0]      opnd_ff, opnd_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic [DIGIT_W-1:0]         digit;
   logic signed [A_W+DIGIT_W:0] partial;

   // most significant digit first, horner style
   assign digit   = dt_ff[DT_PAD_W-1 -: DIGIT_W];
   assign partial = opnd_ff * $signed({1'b0, digit});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dt_in   = dt_ff;
      opnd_in = opnd_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_DIGITS);
         dt_in   = DT_PAD_W'(step_size);
         opnd_in = operand;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< DIGIT_W) + PROD_W'(partial);
         dt_in  = dt_ff << DIGIT_W;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff   <= dt_in;
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
   end

   // arithmetic shift right by FRAC_BITS is the upper slice of the exact product
   assign done    = done_ff;
   assign product = acc_ff[PROD_W-1:FRAC_BITS];

endmodule

`default_nettype wire

### design/rk4ho_div6.sv
// bit-serial divide by six of an unsigned magnitude, one quotient bit per cycle
// standalone, no package needed
`default_nettype none

module rk4ho_div6 #(
   parameter int WIDTH = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam logic [3:0] DIVISOR = 4'd6;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [2:0]       rem_ff, rem_in;
   logic [3:0]       trial;
   logic             qbit;

   // dividend bits leave at the top, quotient bits enter at the bottom
   assign trial = {rem_ff, sh_ff[WIDTH-1]};
   assign qbit  = (trial >= DIVISOR);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         sh_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? 3'(trial - DIVISOR) : trial[2:0];
         sh_in  = {sh_ff[WIDTH-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

`default_nettype wire

### design/rk4_harmonic_oscillator_step.sv
// top level of the rk4 harmonic oscillator step block: control, state, csr
// depends on rk4ho_pkg, rk4ho_mul, rk4ho_div6 and the assertion macro header
//
// usage:
//   req channel: one word per command, req_tdata[0] = restart. restart reloads
//   x and v from the initial registers and clears time; otherwise one rk4 step
//   of size step_size is taken.
//   rsp channel: exactly one word per command with x, v, time and tuser =
//   saturated (x or v clamped at the final update of this step).
//   csr channel: index 0 step_size, 1 initial_position, 2 initial_velocity;
//   always ready, write only while no command is in flight.
//   a restart goes from idle straight to the output stage. a step runs four
//   stages on two 4-bit digit-serial multipliers, then a bit-serial divide by
//   six of the S_W-bit weighted sum after its load state; each result is then
//   registered into the output register.
//   commands are processed one at a time; req_tready returns the cycle after a
//   result is loaded into the output register, even if that result is not taken.
//   a stalled rsp holds its word; a finished step waits until the output
//   register frees.
//   reset: x = 1.0, v = 0, time = 0, registers at their reset values.
`default_nettype none
`include "rk4_harmonic_oscillator_step_macros.svh"

module rk4_harmonic_oscillator_step #(
   parameter int FRAC_BITS  = rk4ho_pkg::FRAC_BITS_DEF,
   parameter int TIME_WIDTH = rk4ho_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] restart, [7:1] zero
   input  logic [rk4ho_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] position_out, [63:32] velocity_out, [111:64] time_out
   output logic [rk4ho_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] saturated
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rk4ho_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rk4ho_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rk4ho_pkg::*;

   localparam int K_W  = PROD_W - FRAC_BITS;
   localparam int S_W  = K_W + 3;
   localparam int W_W  = S_W + 1;
   localparam int TX_W = (TIME_WIDTH > TIME_OUT_W) ? TIME_WIDTH : TIME_OUT_W;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_LOAD     = 6'b000010,
      S_MUL      = 6'b000100,
      S_DIV_LOAD = 6'b001000,
      S_DIV      = 6'b010000,
      S_OUT      = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                stage_ff, stage_in;
   logic [DT_W-1:0]           step_size_ff, step_size_in;
   logic signed [POS_W-1:0]   init_pos_ff, init_pos_in;
   logic signed [POS_W-1:0]   init_vel_ff, init_vel_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [POS_W-1:0]   vel_ff, vel_in;
   logic [TIME_WIDTH-1:0]     time_ff, time_in;
   logic                      sat_ff, sat_in;
   logic signed [S_W-1:0]     sum_x_ff, sum_x_in;
   logic signed [S_W-1:0]     sum_v_ff, sum_v_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic                      mul_start, div_start;
   logic                      mul_x_done, mul_v_done;
   logic                      div_x_done, div_v_done;
   logic signed [K_W-1:0]     k_x, k_v;
   logic signed [K_W-1:0]     half_x, half_v;
   logic signed [S_W-1:0]     wk_x, wk_v;
   logic [S_W-1:0]            mag_x, mag_v;
   logic [S_W-1:0]            quo_x, quo_v;
   logic signed [W_W-1:0]     add_x, add_v;
   logic signed [W_W-1:0]     sx, sv;
   logic                      ovf_x, ovf_v;
   logic signed [POS_W-1:0]   cl_x, cl_v;
   logic signed [A_W-1:0]     op_x, op_v;
   logic [TX_W-1:0]           time_ext;

   rk4ho_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand   (op_x),
      .step_size (step_size_ff),
      .done      (mul_x_done),
      .product   (k_x)
   );

   rk4ho_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_v (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand   (op_v),
      .step_size (step_size_ff),
      .done      (mul_v_done),
      .product   (k_v)
   );

   rk4ho_div6 #(.WIDTH(S_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_x),
      .done     (div_x_done),
      .quotient (quo_x)
   );

   rk4ho_div6 #(.WIDTH(S_W)) u_div_v (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_v),
      .done     (div_v_done),
      .quotient (quo_v)
   );

   // stages two and three use k/2, stage four uses k3 whole
   assign half_x = (stage_ff == 2'd3) ? k_x : (k_x >>> 1);
   assign half_v = (stage_ff == 2'd3) ? k_v : (k_v >>> 1);

   // one adder and clamp per lane, shared by stage operands and the final update
   always_comb begin
      if (state_ff == S_DIV) begin
         add_x = sum_x_ff[S_W-1] ? -$signed(W_W'(quo_x)) : $signed(W_W'(quo_x));
         add_v = sum_v_ff[S_W-1] ? -$signed(W_W'(quo_v)) : $signed(W_W'(quo_v));
      end else begin
         add_x = W_W'(half_x);
         add_v = W_W'(half_v);
      end
   end

   assign sx    = W_W'(pos_ff) + add_x;
   assign sv    = W_W'(vel_ff) + add_v;
   assign ovf_x = !((&sx[W_W-1:POS_W-1]) || !(|sx[W_W-1:POS_W-1]));
   assign ovf_v = !((&sv[W_W-1:POS_W-1]) || !(|sv[W_W-1:POS_W-1]));
   assign cl_x  = ovf_x ? (sx[W_W-1] ? Q_MIN : Q_MAX) : sx[POS_W-1:0];
   assign cl_v  = ovf_v ? (sv[W_W-1] ? Q_MIN : Q_MAX) : sv[POS_W-1:0];

   // dx/dt = v, dv/dt = -x
   assign op_x = (stage_ff == 2'd0) ? A_W'(vel_ff) : A_W'(cl_v);
   assign op_v = -((stage_ff == 2'd0) ? A_W'(pos_ff) : A_W'(cl_x));

   assign wk_x = (stage_ff == 2'd1 || stage_ff == 2'd2) ? (S_W'(k_x) <<< 1) : S_W'(k_x);
   assign wk_v = (stage_ff == 2'd1 || stage_ff == 2'd2) ? (S_W'(k_v) <<< 1) : S_W'(k_v);

   assign mag_x = sum_x_ff[S_W-1] ? S_W'(-sum_x_ff) : S_W'(sum_x_ff);
   assign mag_v = sum_v_ff[S_W-1] ? S_W'(-sum_v_ff) : S_W'(sum_v_ff);

   assign time_ext = TX_W'(time_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      time_in      = time_ff;
      sat_in       = sat_ff;
      sum_x_in     = sum_x_ff;
      sum_v_in     = sum_v_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  pos_in   = init_pos_ff;
                  vel_in   = init_vel_ff;
                  time_in  = '0;
                  sat_in   = 1'b0;
                  state_in = S_OUT;
               end else begin
                  stage_in = 2'd0;
                  sum_x_in = '0;
                  sum_v_in = '0;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            mul_start = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (mul_x_done) begin
               sum_x_in = sum_x_ff + wk_x;
               sum_v_in = sum_v_ff + wk_v;
               if (stage_ff == 2'd3) begin
                  state_in = S_DIV_LOAD;
               end else begin
                  stage_in = stage_ff + 2'd1;
                  state_in = S_LOAD;
               end
            end
         end
         S_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_x_done) begin
               pos_in   = cl_x;
               vel_in   = cl_v;
               sat_in   = ovf_x | ovf_v;
               time_in  = time_ff + TIME_WIDTH'(step_size_ff);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {time_ext[TIME_OUT_W-1:0], vel_ff, pos_ff};
               rsp_sat_in   = sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      step_size_in = step_size_ff;
      init_pos_in  = init_pos_ff;
      init_vel_in  = init_vel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_SIZE: step_size_in = csr_data[DT_W-1:0];
            CSR_INIT_POS:  init_pos_in  = csr_data[POS_W-1:0];
            CSR_INIT_VEL:  init_vel_in  = csr_data[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_size_ff <= STEP_SIZE_RST;
         init_pos_ff  <= INIT_POS_RST;
         init_vel_ff  <= INIT_VEL_RST;
         pos_ff       <= INIT_POS_RST;
         vel_ff       <= INIT_VEL_RST;
         time_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_size_ff <= step_size_in;
         init_pos_ff  <= init_pos_in;
         init_vel_ff  <= init_vel_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         time_ff      <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      sat_ff      <= sat_in;
      sum_x_ff    <= sum_x_in;
      sum_v_ff    <= sum_v_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // both multiplier lanes start together and must finish together
   `RK4HO_ASSERT_SAME(a_mul_lockstep, clock, reset,
      mul_x_done || mul_v_done, mul_x_done && mul_v_done && state_ff == S_MUL,
      "multiplier lanes out of step")

   // dividers only report while the controller waits for them
   `RK4HO_ASSERT_SAME(a_div_in_state, clock, reset,
      div_x_done || div_v_done, div_x_done && div_v_done && state_ff == S_DIV,
      "divider done outside the divide phase")

   // a step command always enters the first multiply stage
   `RK4HO_ASSERT_NEXT(a_step_starts, clock, reset,
      req_tvalid && req_tready && !req_tdata[0], state_ff == S_LOAD && stage_ff == 2'd0,
      "step command did not start stage one")

   // a finished item is loaded into the output register and the block frees
   `RK4HO_ASSERT_NEXT(a_result_loaded, clock, reset,
      state_ff == S_OUT && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == S_IDLE,
      "result not loaded into output register")

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// testbench for rk4_harmonic_oscillator_step: random commands, csr settings and stalls,
// each response word checked against an in-bench fixed-point rk4 tracker
// depends on rk4ho_pkg and the rk4_harmonic_oscillator_step rtl

module tb;
   import rk4ho_pkg::*;

   localparam int COMMAND_TARGET = 1850;
   localparam int TAIL_CYCLES    = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam longint POS_TOP    = longint'(Q_MAX);
   localparam longint POS_BOTTOM = longint'(Q_MIN);

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic signed [POS_W-1:0] velocity;
      logic [TIME_OUT_W-1:0]   elapsed;
      logic                    saturated;
   } osc_word_type;

   class rk4_tracker_type;
      logic [DT_W-1:0]             step;
      logic signed [POS_W-1:0]     start_pos;
      logic signed [POS_W-1:0]     start_vel;
      logic signed [POS_W-1:0]     pos;
      logic signed [POS_W-1:0]     vel;
      logic [TIME_WIDTH_DEF-1:0]   elapsed;
      osc_word_type                awaited[$];
      int                          mismatches;
      int                          commands;
      int                          restarts;
      int                          sat_steps;
      int                          words;

      function new();
         step      = STEP_SIZE_RST;
         start_pos = INIT_POS_RST;
         start_vel = INIT_VEL_RST;
         pos       = INIT_POS_RST;
         vel       = INIT_VEL_RST;
         elapsed   = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_STEP_SIZE: step = data[DT_W-1:0];
            CSR_INIT_POS:  start_pos = data;
            CSR_INIT_VEL:  start_vel = data;
            default: ;
         endcase
      endfunction

      // exact product, then arithmetic shift (floor)
      function longint by_dt(longint a);
         return (longint'(step) * a) >>> FRAC_BITS_DEF;
      endfunction

      function longint clip(longint v, inout bit hit);
         if (v > POS_TOP) begin
            hit = 1'b1;
            return POS_TOP;
         end
         if (v < POS_BOTTOM) begin
            hit = 1'b1;
            return POS_BOTTOM;
         end
         return v;
      endfunction

      function void note_command(bit restart);
         osc_word_type want;
         longint x, v, tx, tv;
         longint k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v;
         bit sat, spill;
         sat   = 1'b0;
         spill = 1'b0;
         commands++;
         if (restart) begin
            restarts++;
            pos     = start_pos;
            vel     = start_vel;
            elapsed = '0;
         end else begin
            x = pos;
            v = vel;
            k1x = by_dt(v);
            k1v = by_dt(-x);
            // stage clamps do not raise the flag
            tx  = clip(x + (k1x >>> 1), spill);
            tv  = clip(v + (k1v >>> 1), spill);
            k2x = by_dt(tv);
            k2v = by_dt(-tx);
            tx  = clip(x + (k2x >>> 1), spill);
            tv  = clip(v + (k2v >>> 1), spill);
            k3x = by_dt(tv);
            k3v = by_dt(-tx);
            tx  = clip(x + k3x, spill);
            tv  = clip(v + k3v, spill);
            k4x = by_dt(tv);
            k4v = by_dt(-tx);
            // longint division truncates toward zero
            pos = POS_W'(clip(x + (k1x + 2 * k2x + 2 * k3x + k4x) / 6, sat));
            vel = POS_W'(clip(v + (k1v + 2 * k2v + 2 * k3v + k4v) / 6, sat));
            elapsed = elapsed + TIME_WIDTH_DEF'(step);
         end
         if (sat)
            sat_steps++;
         want.position  = pos;
         want.velocity  = vel;
         want.elapsed   = elapsed[TIME_OUT_W-1:0];
         want.saturated = sat;
         awaited.push_back(want);
      endfunction

      function void compare(string what, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
         end
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] word, logic sat_flag);
         osc_word_type want;
         words++;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: response word with nothing outstanding, expected none, got %h",
                     $time, word);
            return;
         end
         want = awaited.pop_front();
         // compare raw bit patterns, no sign extension
         compare("position", 64'(want.position[POS_W-1:0]), 64'(word[POS_W-1:0]));
         compare("velocity", 64'(want.velocity[POS_W-1:0]), 64'(word[2*POS_W-1:POS_W]));
         compare("time", 64'(want.elapsed), 64'(word[RSP_DATA_W-1:2*POS_W]));
         compare("saturated", 64'(want.saturated), 64'(sat_flag));
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   rk4_tracker_type tracker = new();
   bit              calm;
   int              sent;
   int              reg_writes;

   rk4_harmonic_oscillator_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_command(bit restart);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(restart);
      do @(posedge clock); while (!(req_tvalid === 1'b1 && req_tready === 1'b1));
      tracker.note_command(restart);
      sent++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid === 1'b1 && csr_ready === 1'b1));
      tracker.set_register(idx, data);
      reg_writes++;
   endtask

   // stop sending and wait for every outstanding word
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.awaited.size() != 0);
   endtask

   function automatic logic [DT_W-1:0] pick_step();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return DT_W'($urandom_range(1, 4096));
         default: return DT_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_level();
      case ($urandom_range(0, 7))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return '0;
         3: return CSR_DATA_W'($urandom_range(0, 4096));
         default: return $urandom;
      endcase
   endfunction

   initial begin : response_sink
      int stall;
      int burst;
      burst = 0;
      forever begin
         if (burst > 0) begin
            stall = 0;
            burst--;
         end else if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(10, 40);
            stall = 0;
         end else begin
            stall = $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
         tracker.check_word(rsp_tdata, rsp_tuser);
      end
   end

   initial begin : stimulus
      int phase_len;
      calm = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, then a restart
      send_command(1'b0);
      send_command(1'b0);
      send_command(1'b1);
      drain();

      // largest dt from the corner: final clamp, then a restart clears the flag
      write_register(CSR_STEP_SIZE, '1);
      write_register(CSR_INIT_POS, Q_MAX);
      write_register(CSR_INIT_VEL, Q_MAX);
      csr_valid <= 1'b0;
      send_command(1'b1);
      send_command(1'b0);
      send_command(1'b0);
      send_command(1'b0);
      send_command(1'b1);
      drain();

      // zero dt with junk in the ignored bits, plus a write to an unused index
      write_register(CSR_STEP_SIZE, 32'hF000_0000);
      write_register(CSR_INIT_POS, Q_MIN);
      write_register(CSR_INIT_VEL, Q_MIN);
      write_register(CSR_UNUSED, '1);
      csr_valid <= 1'b0;
      send_command(1'b1);
      send_command(1'b0);
      send_command(1'b0);
      drain();

      write_register(CSR_STEP_SIZE, '1);
      write_register(CSR_INIT_VEL, Q_MAX);
      csr_valid <= 1'b0;
      send_command(1'b1);
      send_command(1'b0);
      send_command(1'b0);
      send_command(1'b0);
      drain();

      write_register(CSR_INIT_POS, Q_MAX);
      write_register(CSR_INIT_VEL, Q_MIN);
      csr_valid <= 1'b0;
      send_command(1'b1);
      send_command(1'b0);
      send_command(1'b0);

      // random phases: new settings, then mostly steps after a restart
      while (sent < COMMAND_TARGET) begin
         drain();
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) != 0)
            write_register(CSR_STEP_SIZE, {4'($urandom), pick_step()});
         if ($urandom_range(0, 2) != 0)
            write_register(CSR_INIT_POS, pick_level());
         if ($urandom_range(0, 2) != 0)
            write_register(CSR_INIT_VEL, pick_level());
         if ($urandom_range(0, 5) == 0)
            write_register(CSR_UNUSED, $urandom);
         csr_valid <= 1'b0;
         phase_len = $urandom_range(20, 120);
         send_command($urandom_range(0, 4) != 0);
         repeat (phase_len - 1)
            send_command($urandom_range(0, 19) == 0);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d commands (%0d restarts) across %0d register writes",
               tracker.commands, tracker.restarts, reg_writes);
      $display("compared %0d response words, %0d steps clamped at the final update",
               tracker.words, tracker.sat_steps);
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #25_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
